FILE: src/abac_pkg.sv
// Shared constants, configuration codes and control structs for the block
// average and calibration unit. No dependencies.
`timescale 1ns / 1ps

package abac_pkg;

    localparam int AXES       = 3;
    localparam int RAW_W      = 16;
    localparam int SAMPLE_W   = 12;
    localparam int SAMPLE_LSB = RAW_W - SAMPLE_W;
    localparam int OFFSET_W   = 12;
    localparam int CPG_W      = 12;
    localparam int CFG_DATA_W = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int DIFF_W     = SAMPLE_W + 1;
    localparam int ACCEL_W    = 27;
    localparam int MAG_W      = ACCEL_W - 1;
    localparam int MILLI_G_W  = 14;

    localparam logic [MILLI_G_W-1:0] MILLI_G = MILLI_G_W'(9807);

    localparam int WINDOW_DEF = 10;

    localparam logic [OFFSET_W-1:0] ZERO_CODE_RST    = OFFSET_W'(2048);
    localparam logic [CPG_W-1:0]    COUNTS_PER_G_RST = CPG_W'(819);
    localparam logic                AVERAGING_ON_RST = 1'b1;

    localparam int IN_DATA_W  = AXES * RAW_W;
    localparam int IN_USER_W  = AXES;
    localparam int OUT_DATA_W = ((AXES * ACCEL_W + 7) / 8) * 8;
    localparam int OUT_USER_W = AXES;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ZERO_CODE    = 2'd0,
        CFG_COUNTS_PER_G = 2'd1,
        CFG_AVERAGING_ON = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic capture;
        logic start_avg;
        logic take_avg;
        logic mul;
        logic start_scl;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic report;
        logic avg_mode;
        logic div_done;
        logic out_free;
    } t_status;

endpackage

FILE: src/abac_div.sv
// Restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on nothing; used by abac_datapath, one per axis lane.
`timescale 1ns / 1ps

module abac_div #(
    parameter int N_W = 26,
    parameter int D_W = 12
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [N_W-1:0] i_dividend,
    input  logic [D_W-1:0] i_divisor,
    output logic [N_W-1:0] o_quotient,
    output logic           o_done
);

    localparam int STEP_W = $clog2(N_W + 1);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(N_W - 1);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [N_W-1:0]    r_quo;
    logic [D_W-1:0]    r_rem;
    logic [D_W-1:0]    r_dvs;

    logic [D_W:0]   w_shift;
    logic [D_W:0]   w_trial;
    logic           w_ge;
    logic [D_W-1:0] n_rem;

    assign w_shift = {r_rem, r_quo[N_W-1]};
    assign w_trial = w_shift - {1'b0, r_dvs};
    assign w_ge    = w_shift >= {1'b0, r_dvs};
    assign n_rem   = w_ge ? w_trial[D_W-1:0] : w_shift[D_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[N_W-2:0], w_ge};
            r_rem <= n_rem;
        end
    end

    assign o_quotient = r_quo;
    assign o_done     = r_done;

endmodule

FILE: src/abac_datapath.sv
// Datapath: window accumulators, three axis lanes with a divider each,
// calibration multiply and the output word register. Uses abac_pkg, abac_div.
`timescale 1ns / 1ps

module abac_datapath #(
    parameter int WINDOW = abac_pkg::WINDOW_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  abac_pkg::t_cmd                  i_cmd,
    output abac_pkg::t_status               o_status,
    input  logic [abac_pkg::OFFSET_W-1:0]   i_zero_code,
    input  logic [abac_pkg::CPG_W-1:0]      i_counts_per_g,
    input  logic                            i_averaging_on,
    input  logic [abac_pkg::IN_DATA_W-1:0]  i_s_tdata,
    input  logic [abac_pkg::IN_USER_W-1:0]  i_s_tuser,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [abac_pkg::OUT_DATA_W-1:0] o_m_tdata,
    output logic [abac_pkg::OUT_USER_W-1:0] o_m_tuser
);

    import abac_pkg::*;

    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam int SUM_W = SAMPLE_W + CNT_W;
    localparam logic [CNT_W-1:0] WIN_LAST = CNT_W'(WINDOW - 1);
    localparam logic signed [ACCEL_W-1:0] MILLI_S = ACCEL_W'({1'b0, MILLI_G});

    logic [CNT_W-1:0] r_frames;
    logic             r_report;
    logic             r_avg_mode;
    logic             r_m_tvalid;
    logic [AXES-1:0]  w_done;
    logic [CPG_W-1:0] w_scl_dvs;

    logic [AXES*ACCEL_W-1:0] w_out_data;
    logic [AXES-1:0]         w_out_user;
    logic [OUT_DATA_W-1:0]   r_m_tdata;
    logic [OUT_USER_W-1:0]   r_m_tuser;

    // zero divisor counts as one
    assign w_scl_dvs = (i_counts_per_g == '0) ? CPG_W'(1) : i_counts_per_g;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frames   <= '0;
            r_report   <= 1'b0;
            r_avg_mode <= 1'b0;
        end else if (i_cmd.capture) begin
            r_avg_mode <= i_averaging_on;
            r_report   <= !i_averaging_on || (r_frames == WIN_LAST);
            if (i_averaging_on) begin
                r_frames <= r_frames + 1'b1;
            end
        end else if (i_cmd.start_avg) begin
            r_frames <= '0;
        end
    end

    for (genvar a = 0; a < AXES; a++) begin : g_lane
        logic [SAMPLE_W-1:0]       w_sample;
        logic                      w_ok_in;
        logic [SUM_W-1:0]          r_sum;
        logic [CNT_W-1:0]          r_cnt;
        logic [SAMPLE_W-1:0]       r_val;
        logic                      r_ok;
        logic signed [ACCEL_W-1:0] r_prod;
        logic signed [DIFF_W-1:0]  w_diff;
        logic signed [ACCEL_W-1:0] w_prod;
        logic [MAG_W-1:0]          w_mag;
        logic [MAG_W-1:0]          w_dividend;
        logic [CPG_W-1:0]          w_divisor;
        logic [MAG_W-1:0]          w_quo;
        logic signed [ACCEL_W-1:0] w_res;

        assign w_sample = i_s_tdata[a*RAW_W + SAMPLE_LSB +: SAMPLE_W];
        assign w_ok_in  = !i_s_tuser[a];

        assign w_diff = $signed({1'b0, r_val}) - $signed({1'b0, i_zero_code});
        assign w_prod = ACCEL_W'(w_diff) * MILLI_S;
        assign w_mag  = r_prod[ACCEL_W-1] ? MAG_W'(-r_prod) : MAG_W'(r_prod);

        assign w_dividend = i_cmd.start_avg ? MAG_W'(r_sum) : w_mag;
        assign w_divisor  = i_cmd.start_avg ? CPG_W'(r_cnt) : w_scl_dvs;

        // truncate toward zero: divide the magnitude, put the sign back
        assign w_res = r_prod[ACCEL_W-1] ? -$signed({1'b0, w_quo}) : $signed({1'b0, w_quo});

        // window sums and counts of valid samples
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sum <= '0;
                r_cnt <= '0;
            end else if (i_cmd.capture && i_averaging_on) begin
                if (w_ok_in) begin
                    r_sum <= r_sum + SUM_W'(w_sample);
                    r_cnt <= r_cnt + 1'b1;
                end
            end else if (i_cmd.start_avg) begin
                r_sum <= '0;
                r_cnt <= '0;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_cmd.capture) begin
                r_val <= w_sample;
                r_ok  <= w_ok_in;
            end else if (i_cmd.start_avg) begin
                r_ok <= (r_cnt != '0);
            end else if (i_cmd.take_avg) begin
                r_val <= w_quo[SAMPLE_W-1:0];
            end
            if (i_cmd.mul) begin
                r_prod <= w_prod;
            end
        end

        abac_div #(
            .N_W (MAG_W),
            .D_W (CPG_W)
        ) u_div (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_start    (i_cmd.start_avg || i_cmd.start_scl),
            .i_dividend (w_dividend),
            .i_divisor  (w_divisor),
            .o_quotient (w_quo),
            .o_done     (w_done[a])
        );

        assign w_out_data[a*ACCEL_W +: ACCEL_W] = r_ok ? w_res : '0;
        assign w_out_user[a]                    = r_ok;
    end

    // output word register, parts the result side from the input side
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_m_tvalid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_m_tdata <= OUT_DATA_W'(w_out_data);
            r_m_tuser <= w_out_user;
        end
    end

    assign o_status.report   = r_report;
    assign o_status.avg_mode = r_avg_mode;
    assign o_status.div_done = &w_done;
    assign o_status.out_free = !r_m_tvalid || i_m_tready;

    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = r_m_tdata;
    assign o_m_tuser  = r_m_tuser;

endmodule

FILE: src/abac_ctrl.sv
// Controller state machine: sequences capture, averaging division,
// calibration multiply, scaling division and output load. Uses abac_pkg.
`timescale 1ns / 1ps

module abac_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  abac_pkg::t_status i_status,
    output abac_pkg::t_cmd    o_cmd
);

    import abac_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_DECIDE = 7'b0000010,
        S_AVG    = 7'b0000100,
        S_MUL    = 7'b0001000,
        S_SCLGO  = 7'b0010000,
        S_SCL    = 7'b0100000,
        S_OUT    = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (!i_status.report) begin
                    n_state = S_IDLE;
                end else if (i_status.avg_mode) begin
                    o_cmd.start_avg = 1'b1;
                    n_state         = S_AVG;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_AVG: begin
                if (i_status.div_done) begin
                    o_cmd.take_avg = 1'b1;
                    n_state        = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_SCLGO;
            end
            S_SCLGO: begin
                o_cmd.start_scl = 1'b1;
                n_state         = S_SCL;
            end
            S_SCL: begin
                if (i_status.div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_s_tready = (r_state == S_IDLE);

endmodule

FILE: src/accel_block_average_calibrate_top.sv
// Top level of the three-axis block average and calibration unit.
// Uses abac_pkg, abac_ctrl, abac_datapath.
//
// Each input word is one accelerometer frame: three 16-bit converter words
// whose bits 15..4 hold the sample, and a read-failed flag per axis. With
// averaging on, each frame is added into per-axis window sums; every
// WINDOW-th frame each axis is averaged over its valid samples (truncating)
// and one output word is given. With averaging off, every frame gives one
// output word. Each reported value is converted to milli m/s^2 as
// (value - zero_code) * 9807 / counts_per_g, truncating toward zero; a
// counts_per_g of 0 acts as 1. An axis with no valid sample reports valid 0
// and acceleration 0. Each reported frame runs through the per-axis restoring
// divider, which yields one quotient bit a cycle over 26 bits and is used
// once for the window average when a window closes and once for the scaling.
// The three axes run in parallel lanes. A finished word waits in the output
// register while the next frame is taken. Write the configuration registers
// only while no frame is in flight; a write takes effect at the edge that
// carries it.
`timescale 1ns / 1ps

module accel_block_average_calibrate_top #(
    parameter int WINDOW = abac_pkg::WINDOW_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration write port
    input  logic                             i_cfg_we,
    input  logic [abac_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [abac_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // frame input
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // raw_x [15:0], raw_y [31:16], raw_z [47:32]
    input  logic [abac_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // x_failed [0], y_failed [1], z_failed [2]
    input  logic [abac_pkg::IN_USER_W-1:0]   s_axis_tuser,
    // result output
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // accel_x [26:0], accel_y [53:27], accel_z [80:54], zero [87:81]
    output logic [abac_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // x_valid [0], y_valid [1], z_valid [2]
    output logic [abac_pkg::OUT_USER_W-1:0]  m_axis_tuser
);

    import abac_pkg::*;

    logic [OFFSET_W-1:0] r_zero_code;
    logic [CPG_W-1:0]    r_counts_per_g;
    logic                r_averaging_on;

    t_cmd    w_cmd;
    t_status w_status;

    // configuration registers; writes to an unused index are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero_code    <= ZERO_CODE_RST;
            r_counts_per_g <= COUNTS_PER_G_RST;
            r_averaging_on <= AVERAGING_ON_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_ZERO_CODE:    r_zero_code    <= i_cfg_data[OFFSET_W-1:0];
                CFG_COUNTS_PER_G: r_counts_per_g <= i_cfg_data[CPG_W-1:0];
                CFG_AVERAGING_ON: r_averaging_on <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    abac_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    abac_datapath #(
        .WINDOW (WINDOW)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .i_zero_code    (r_zero_code),
        .i_counts_per_g (r_counts_per_g),
        .i_averaging_on (r_averaging_on),
        .i_s_tdata      (s_axis_tdata),
        .i_s_tuser      (s_axis_tuser),
        .o_m_tvalid     (m_axis_tvalid),
        .i_m_tready     (m_axis_tready),
        .o_m_tdata      (m_axis_tdata),
        .o_m_tuser      (m_axis_tuser)
    );

endmodule

FILE: src/abac_checker.sv
// Port-level checks for the block average and calibration top level,
// bound to it below. Uses abac_pkg.
`timescale 1ns / 1ps

module abac_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [abac_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input logic [abac_pkg::OUT_USER_W-1:0] m_axis_tuser
);

    import abac_pkg::*;

    // hold a stalled result word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("stalled result word changed");

    // one frame at a time: no word taken in the cycle after a word is taken
    a_one_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while frame in progress");

    // an axis without valid samples reports zero
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            (m_axis_tuser[0] || m_axis_tdata[ACCEL_W-1:0] == '0) &&
            (m_axis_tuser[1] || m_axis_tdata[2*ACCEL_W-1:ACCEL_W] == '0) &&
            (m_axis_tuser[2] || m_axis_tdata[3*ACCEL_W-1:2*ACCEL_W] == '0))
        else $error("invalid axis carries nonzero acceleration");

    // padding above the three fields stays zero
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[OUT_DATA_W-1:AXES*ACCEL_W] == '0)
        else $error("padding bits of result word set");

endmodule

bind accel_block_average_calibrate_top abac_checker u_abac_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
